// ----- hdl/dpes_pkg.sv -----
// dpes_pkg: shared types, codes and sizes for the edge swap unit
// no dependencies; imported by every module of the block
package dpes_pkg;

	localparam int DPES_MAX_NODES = 256;
	localparam int DPES_MAX_EDGES = 4096;

	localparam int NODE_BITS   = 8;
	localparam int INDEX_BITS  = 12;
	localparam int COUNT_BITS  = 13;
	localparam int STATUS_BITS = 3;
	localparam int SWAPS_BITS  = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	// request modes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_SWAP = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// result status codes
	localparam logic [STATUS_BITS-1:0] STAT_LOADED  = 3'd0;
	localparam logic [STATUS_BITS-1:0] STAT_SWAPPED = 3'd1;
	localparam logic [STATUS_BITS-1:0] STAT_SHARED  = 3'd2;
	localparam logic [STATUS_BITS-1:0] STAT_EXISTS  = 3'd3;
	localparam logic [STATUS_BITS-1:0] STAT_READ    = 3'd4;
	localparam logic [STATUS_BITS-1:0] STAT_BAD     = 3'd5;

	// register word index
	localparam logic [CFG_ADDR_W-3:0] REG_EDGE_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]            mode;
		logic [INDEX_BITS-1:0] first_index;
		logic [INDEX_BITS-1:0] second_index;
		logic [NODE_BITS-1:0]  node_a;
		logic [NODE_BITS-1:0]  node_b;
		logic                  coin;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [NODE_BITS-1:0]   edge_first;
		logic [NODE_BITS-1:0]   edge_second;
		logic [SWAPS_BITS-1:0]  accepted_swaps;
	} res_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node_u;
		logic [NODE_BITS-1:0] node_v;
	} edge_t;

	typedef struct packed {
		logic                  we;
		logic [INDEX_BITS-1:0] waddr;
		edge_t                 wdata;
		logic [INDEX_BITS-1:0] raddr;
	} edge_cmd_t;

	typedef struct packed {
		logic                 rd;
		logic                 wr;
		logic [NODE_BITS-1:0] row;
		logic [NODE_BITS-1:0] probe;
		logic                 clr_en;
		logic [NODE_BITS-1:0] clr;
		logic [NODE_BITS-1:0] set;
	} adj_cmd_t;

endpackage

// ----- hdl/dpes_edge_mem.sv -----
// dpes_edge_mem: edge list storage, one write and one registered read per cycle
// depends on dpes_pkg
module dpes_edge_mem #(
	parameter int MAX_EDGES = dpes_pkg::DPES_MAX_EDGES
) (
	input  logic                clk,
	input  dpes_pkg::edge_cmd_t cmd,
	output dpes_pkg::edge_t     rdata
);
	import dpes_pkg::*;

	localparam int EDGE_W = $clog2(MAX_EDGES);

	edge_t mem [MAX_EDGES];
	edge_t rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[EDGE_W'(cmd.waddr)] <= cmd.wdata;
		end
		rdata_q <= mem[EDGE_W'(cmd.raddr)];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/dpes_adj_mem.sv -----
// dpes_adj_mem: adjacency bitmap rows with read-modify-write and a clearing pass
// depends on dpes_pkg
module dpes_adj_mem #(
	parameter int MAX_NODES = dpes_pkg::DPES_MAX_NODES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dpes_pkg::adj_cmd_t cmd,
	output logic               probe_bit,
	output logic               busy
);
	import dpes_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);

	logic [MAX_NODES-1:0] mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_q;
	logic [NODE_W-1:0]    probe_q;
	logic                 busy_q;
	logic [NODE_W-1:0]    clr_cnt_q;

	logic                 we;
	logic [NODE_W-1:0]    waddr;
	logic [MAX_NODES-1:0] wdata;
	logic [MAX_NODES-1:0] clr_mask;
	logic [MAX_NODES-1:0] set_mask;

	assign clr_mask = cmd.clr_en ? (MAX_NODES'(1) << NODE_W'(cmd.clr)) : '0;
	assign set_mask = MAX_NODES'(1) << NODE_W'(cmd.set);

	// clearing pass owns the write port right after reset
	always_comb begin
		if (busy_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else begin
			we    = cmd.wr;
			waddr = NODE_W'(cmd.row);
			wdata = (row_q & ~clr_mask) | set_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			row_q   <= mem[NODE_W'(cmd.row)];
			probe_q <= NODE_W'(cmd.probe);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == NODE_W'(MAX_NODES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign probe_bit = row_q[probe_q];
	assign busy      = busy_q;

endmodule

// ----- hdl/degree_preserving_edge_swap_unit.sv -----
// Degree-preserving double edge swap unit.
// Input channel in_valid/in_stall/in_data carries one request: load an edge into a
// slot, read a slot back, or attempt a swap of two slots with a host-supplied coin.
// Output channel out_valid/out_stall/out_data returns exactly one result per request:
// status, the first slot's edge after the step, and the accepted swap count.
// edge_count is set over the APB port (byte address 0); the user must set it only
// while the block is idle, which the block itself does not enforce.
// One request is worked at a time; the edge list and the adjacency bitmap each sit
// in a single-port-write memory with a registered read, and every adjacency update
// is a row read followed by a row write. A load does two row read-modify-writes and
// an accepted swap four; the next request is taken once the result is registered.
// After reset the bitmap is cleared one row per cycle, every row in turn, with
// in_stall held high; configuration writes are taken meanwhile.
// If out_stall holds a result, the next request is still accepted and worked,
// and its result waits in the final step until the output register frees up.
// depends on dpes_pkg, dpes_edge_mem, dpes_adj_mem
module degree_preserving_edge_swap_unit #(
	parameter int MAX_NODES = dpes_pkg::DPES_MAX_NODES,
	parameter int MAX_EDGES = dpes_pkg::DPES_MAX_EDGES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dpes_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [dpes_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [dpes_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dpes_pkg::req_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dpes_pkg::res_t                    out_data
);
	import dpes_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_READ   = 4'd1;
	localparam logic [3:0] S_SW_E1  = 4'd2;
	localparam logic [3:0] S_SW_E2  = 4'd3;
	localparam logic [3:0] S_SW_C1  = 4'd4;
	localparam logic [3:0] S_SW_C2  = 4'd5;
	localparam logic [3:0] S_RMW_RD = 4'd6;
	localparam logic [3:0] S_RMW_WR = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	localparam logic [1:0] STEP_LOAD_LAST = 2'd1;
	localparam logic [1:0] STEP_SWAP_LAST = 2'd3;

	// control
	logic [3:0]            state_q, state_d;
	logic                  out_valid_q, out_valid_d;
	logic [SWAPS_BITS-1:0] count_q, count_d;
	logic [COUNT_BITS-1:0] edge_count_q;

	// request context
	logic [INDEX_BITS-1:0]  fi_q, fi_d, si_q, si_d;
	logic                   coin_q, coin_d, is_load_q, is_load_d, exist_q, exist_d;
	logic [NODE_BITS-1:0]   n1_q, n1_d, n2_q, n2_d, n3_q, n3_d, n4_q, n4_d;
	logic [1:0]             step_q, step_d, last_q, last_d;
	logic [STATUS_BITS-1:0] status_q, status_d;
	logic [NODE_BITS-1:0]   ef_q, ef_d, es_q, es_d;
	res_t                   out_data_q, out_data_d;

	logic                  in_acc;
	logic                  cfg_wr;
	logic [CFG_ADDR_W-3:0] reg_idx;
	logic                  fi_ok, si_ok, na_ok, nb_ok, swap_ok, shared;
	logic [SWAPS_BITS-1:0] cnt_next;
	logic [NODE_BITS-1:0]  rmw_row, rmw_clr, rmw_set;

	edge_cmd_t edge_cmd;
	edge_t     edge_rdata;
	adj_cmd_t  adj_cmd;
	logic      adj_bit;
	logic      adj_busy;

	dpes_edge_mem #(.MAX_EDGES(MAX_EDGES)) u_edge_mem (
		.clk   (clk),
		.cmd   (edge_cmd),
		.rdata (edge_rdata)
	);

	dpes_adj_mem #(.MAX_NODES(MAX_NODES)) u_adj_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (adj_cmd),
		.probe_bit (adj_bit),
		.busy      (adj_busy)
	);

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (reg_idx == REG_EDGE_COUNT) ? CFG_DATA_W'(edge_count_q) : '0;

	assign in_stall = (state_q != S_IDLE) || adj_busy;
	assign in_acc   = in_valid && !in_stall;

	assign fi_ok   = 32'(in_data.first_index) < MAX_EDGES;
	assign si_ok   = 32'(in_data.second_index) < MAX_EDGES;
	assign na_ok   = 32'(in_data.node_a) < MAX_NODES;
	assign nb_ok   = 32'(in_data.node_b) < MAX_NODES;
	assign swap_ok = fi_ok && si_ok
		&& ({1'b0, in_data.first_index} < edge_count_q)
		&& ({1'b0, in_data.second_index} < edge_count_q);

	assign shared = (n1_q == edge_rdata.node_u) || (n1_q == edge_rdata.node_v)
		|| (n2_q == edge_rdata.node_u) || (n2_q == edge_rdata.node_v);

	assign cnt_next = count_q + SWAPS_BITS'(status_q == STAT_SWAPPED);

	// one row update per step: clear the old partner (not on a load), set the new one
	always_comb begin
		unique case (step_q)
			2'd0: begin
				rmw_row = n1_q;
				rmw_clr = n2_q;
				rmw_set = is_load_q ? n2_q : (coin_q ? n3_q : n4_q);
			end
			2'd1: begin
				rmw_row = n2_q;
				rmw_clr = n1_q;
				rmw_set = is_load_q ? n1_q : (coin_q ? n4_q : n3_q);
			end
			2'd2: begin
				rmw_row = n3_q;
				rmw_clr = n4_q;
				rmw_set = coin_q ? n1_q : n2_q;
			end
			default: begin
				rmw_row = n4_q;
				rmw_clr = n3_q;
				rmw_set = coin_q ? n2_q : n1_q;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		count_d     = count_q;
		fi_d        = fi_q;
		si_d        = si_q;
		coin_d      = coin_q;
		is_load_d   = is_load_q;
		exist_d     = exist_q;
		n1_d        = n1_q;
		n2_d        = n2_q;
		n3_d        = n3_q;
		n4_d        = n4_q;
		step_d      = step_q;
		last_d      = last_q;
		status_d    = status_q;
		ef_d        = ef_q;
		es_d        = es_q;
		out_data_d  = out_data_q;

		edge_cmd       = '0;
		edge_cmd.raddr = in_data.first_index;
		adj_cmd        = '0;

		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					fi_d      = in_data.first_index;
					si_d      = in_data.second_index;
					coin_d    = in_data.coin;
					n1_d      = in_data.node_a;
					n2_d      = in_data.node_b;
					step_d    = '0;
					is_load_d = 1'b0;
					status_d  = STAT_BAD;
					ef_d      = '0;
					es_d      = '0;
					state_d   = S_DONE;
					unique case (in_data.mode)
						MODE_LOAD: begin
							if (fi_ok && na_ok && nb_ok) begin
								edge_cmd.we    = 1'b1;
								edge_cmd.waddr = in_data.first_index;
								edge_cmd.wdata = '{node_u: in_data.node_a,
									node_v: in_data.node_b};
								is_load_d = 1'b1;
								last_d    = STEP_LOAD_LAST;
								status_d  = STAT_LOADED;
								ef_d      = in_data.node_a;
								es_d      = in_data.node_b;
								state_d   = S_RMW_RD;
							end
						end
						MODE_READ: begin
							if (fi_ok) begin
								state_d = S_READ;
							end
						end
						MODE_SWAP: begin
							if (swap_ok) begin
								state_d = S_SW_E1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				status_d = STAT_READ;
				ef_d     = edge_rdata.node_u;
				es_d     = edge_rdata.node_v;
				state_d  = S_DONE;
			end
			S_SW_E1: begin
				n1_d           = edge_rdata.node_u;
				n2_d           = edge_rdata.node_v;
				edge_cmd.raddr = si_q;
				state_d        = S_SW_E2;
			end
			S_SW_E2: begin
				n3_d = edge_rdata.node_u;
				n4_d = edge_rdata.node_v;
				ef_d = n1_q;
				es_d = n2_q;
				if (shared) begin
					status_d = STAT_SHARED;
					state_d  = S_DONE;
				end else begin
					adj_cmd.rd    = 1'b1;
					adj_cmd.row   = n1_q;
					adj_cmd.probe = coin_q ? edge_rdata.node_u : edge_rdata.node_v;
					state_d       = S_SW_C1;
				end
			end
			S_SW_C1: begin
				exist_d       = adj_bit;
				adj_cmd.rd    = 1'b1;
				adj_cmd.row   = n2_q;
				adj_cmd.probe = coin_q ? n4_q : n3_q;
				state_d       = S_SW_C2;
			end
			S_SW_C2: begin
				if (exist_q || adj_bit) begin
					status_d = STAT_EXISTS;
					state_d  = S_DONE;
				end else begin
					status_d = STAT_SWAPPED;
					es_d     = coin_q ? n3_q : n4_q;
					last_d   = STEP_SWAP_LAST;
					step_d   = '0;
					state_d  = S_RMW_RD;
				end
			end
			S_RMW_RD: begin
				adj_cmd.rd  = 1'b1;
				adj_cmd.row = rmw_row;
				state_d     = S_RMW_WR;
			end
			S_RMW_WR: begin
				adj_cmd.wr     = 1'b1;
				adj_cmd.row    = rmw_row;
				adj_cmd.clr_en = !is_load_q;
				adj_cmd.clr    = rmw_clr;
				adj_cmd.set    = rmw_set;
				// on a swap, rewrite both slots while the rows are updated
				if (!is_load_q && step_q == 2'd0) begin
					edge_cmd.we    = 1'b1;
					edge_cmd.waddr = fi_q;
					edge_cmd.wdata = '{node_u: n1_q, node_v: (coin_q ? n3_q : n4_q)};
				end else if (!is_load_q && step_q == 2'd1) begin
					edge_cmd.we    = 1'b1;
					edge_cmd.waddr = si_q;
					edge_cmd.wdata = coin_q ? edge_t'{node_u: n2_q, node_v: n4_q}
						: edge_t'{node_u: n3_q, node_v: n2_q};
				end
				if (step_q == last_q) begin
					state_d = S_DONE;
				end else begin
					step_d  = step_q + 2'd1;
					state_d = S_RMW_RD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_data_d = '{status: status_q, edge_first: ef_q, edge_second: es_q,
						accepted_swaps: cnt_next};
					count_d     = cnt_next;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			count_q      <= '0;
			edge_count_q <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			count_q     <= count_d;
			if (cfg_wr && reg_idx == REG_EDGE_COUNT) begin
				edge_count_q <= pwdata[COUNT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		fi_q       <= fi_d;
		si_q       <= si_d;
		coin_q     <= coin_d;
		is_load_q  <= is_load_d;
		exist_q    <= exist_d;
		n1_q       <= n1_d;
		n2_q       <= n2_d;
		n3_q       <= n3_d;
		n4_q       <= n4_d;
		step_q     <= step_d;
		last_q     <= last_d;
		status_q   <= status_d;
		ef_q       <= ef_d;
		es_q       <= es_d;
		out_data_q <= out_data_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/dpes_checker.sv -----
// dpes_checker: port-level assertions for the edge swap unit, bound to the top level
// depends on dpes_pkg and degree_preserving_edge_swap_unit
module dpes_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input dpes_pkg::res_t                  out_data
);
	import dpes_pkg::*;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one request at a time: taking a request closes the input for the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in flight");

	// a new result only comes out of a busy sequencer
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= STAT_BAD)
		else $error("status code out of range");

	// results with the bad index status carry zero edge fields
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_BAD
			|-> out_data.edge_first == '0 && out_data.edge_second == '0)
		else $error("bad index result with nonzero edge");

endmodule

bind degree_preserving_edge_swap_unit dpes_checker u_dpes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- tb/sv/tb_degree_preserving_edge_swap_unit.sv -----
// testbench for the degree preserving edge swap unit: loads, reads and swap attempts
// are checked one for one against a predictor of the edge list and adjacency bitmap
// depends on dpes_pkg and degree_preserving_edge_swap_unit
module tb_degree_preserving_edge_swap_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dpes_pkg::*;

	// mode code that the block answers with a bad index status
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_t out_data;

	degree_preserving_edge_swap_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted copy of the block's state
	logic [NODE_BITS-1:0]  slot_u [DPES_MAX_EDGES];
	logic [NODE_BITS-1:0]  slot_v [DPES_MAX_EDGES];
	logic [DPES_MAX_NODES-1:0] adj_row [DPES_MAX_NODES];
	logic [SWAPS_BITS-1:0] swap_total = '0;
	logic [COUNT_BITS-1:0] edge_limit = '0;

	// stimulus bookkeeping: which slots hold an edge
	bit slot_filled [DPES_MAX_EDGES];
	int filled_slots [$];

	req_t pending_reqs [$];
	res_t expected_results [$];
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   fail_count = 0;

	initial begin
		for (int n = 0; n < DPES_MAX_EDGES; n++) begin
			slot_u[n] = '0;
			slot_v[n] = '0;
			slot_filled[n] = 1'b0;
		end
		for (int n = 0; n < DPES_MAX_NODES; n++)
			adj_row[n] = '0;
	end

	function automatic void set_pair(input logic [NODE_BITS-1:0] a, b, input logic val);
		adj_row[a][b] = val;
		adj_row[b][a] = val;
	endfunction

	function automatic res_t predict_step(input req_t r);
		res_t o;
		logic [NODE_BITS-1:0] v1, v2, v3, v4;
		o = '0;
		o.status = STAT_BAD;
		case (r.mode)
		MODE_LOAD: begin
			slot_u[r.first_index] = r.node_a;
			slot_v[r.first_index] = r.node_b;
			set_pair(r.node_a, r.node_b, 1'b1);
			o.status = STAT_LOADED;
			o.edge_first = r.node_a;
			o.edge_second = r.node_b;
		end
		MODE_READ: begin
			o.status = STAT_READ;
			o.edge_first = slot_u[r.first_index];
			o.edge_second = slot_v[r.first_index];
		end
		MODE_SWAP: begin
			if (r.first_index < edge_limit && r.second_index < edge_limit) begin
				v1 = slot_u[r.first_index];
				v2 = slot_v[r.first_index];
				v3 = slot_u[r.second_index];
				v4 = slot_v[r.second_index];
				if (v1 == v3 || v1 == v4 || v2 == v3 || v2 == v4) begin
					o.status = STAT_SHARED;
				end else if (r.coin) begin
					if (adj_row[v1][v3] || adj_row[v2][v4]) begin
						o.status = STAT_EXISTS;
					end else begin
						set_pair(v1, v2, 1'b0);
						set_pair(v3, v4, 1'b0);
						set_pair(v1, v3, 1'b1);
						set_pair(v2, v4, 1'b1);
						slot_v[r.first_index] = v3;
						slot_u[r.second_index] = v2;
						swap_total++;
						o.status = STAT_SWAPPED;
					end
				end else begin
					if (adj_row[v1][v4] || adj_row[v2][v3]) begin
						o.status = STAT_EXISTS;
					end else begin
						set_pair(v1, v2, 1'b0);
						set_pair(v3, v4, 1'b0);
						set_pair(v1, v4, 1'b1);
						set_pair(v2, v3, 1'b1);
						slot_v[r.first_index] = v4;
						slot_v[r.second_index] = v2;
						swap_total++;
						o.status = STAT_SWAPPED;
					end
				end
				o.edge_first = slot_u[r.first_index];
				o.edge_second = slot_v[r.first_index];
			end
		end
		default: ;
		endcase
		o.accepted_swaps = swap_total;
		return o;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results = {expected_results, predict_step(in_data)};
				pending_reqs.delete(0);
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	res_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t unexpected result: status %0d edge %0d-%0d swaps %0d",
							$realtime, out_data.status, out_data.edge_first,
							out_data.edge_second, out_data.accepted_swaps);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status
							|| out_data.edge_first !== want.edge_first
							|| out_data.edge_second !== want.edge_second
							|| out_data.accepted_swaps !== want.accepted_swaps) begin
						if (fail_count < 10)
							$display("%0t mismatch: exp status %0d edge %0d-%0d swaps %0d, %s %0d %0d-%0d %0d",
								$realtime, want.status, want.edge_first, want.edge_second,
								want.accepted_swaps, "got", out_data.status,
								out_data.edge_first, out_data.edge_second,
								out_data.accepted_swaps);
						fail_count++;
					end
				end
			end
		end
	end

	function automatic void queue_request(input logic [1:0] mode, input int fi, si, a, b,
			input bit coin);
		req_t r;
		r.mode = mode;
		r.first_index = fi[INDEX_BITS-1:0];
		r.second_index = si[INDEX_BITS-1:0];
		r.node_a = a[NODE_BITS-1:0];
		r.node_b = b[NODE_BITS-1:0];
		r.coin = coin;
		if (mode == MODE_LOAD && !slot_filled[r.first_index]) begin
			slot_filled[r.first_index] = 1'b1;
			filled_slots = {filled_slots, int'(r.first_index)};
		end
		pending_reqs = {pending_reqs, r};
	endfunction

	// a loaded slot below edge_limit, so a swap never touches an empty slot
	function automatic bit pick_slot(output int slot);
		slot = 0;
		if (edge_limit == 0)
			return 1'b0;
		for (int n = 0; n < 24; n++) begin
			if (edge_limit <= 256)
				slot = $urandom_range(edge_limit - 1);
			else if (filled_slots.size() != 0)
				slot = filled_slots[$urandom_range(filled_slots.size() - 1)];
			if (slot_filled[slot] && slot < edge_limit)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// edge_count only changes with the block idle
	task automatic begin_phase(input int limit, input int send_pct, input int hold_pct);
		wait_drained();
		send_idle_pct = send_pct;
		stall_pct = hold_pct;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_EDGE_COUNT, 2'b00};
		pwdata <= limit;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		edge_limit = limit[COUNT_BITS-1:0];
	endtask

	task automatic add_random_items(input int count, input int node_span);
		int roll, i, j, slot;
		bit ok;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			ok = 1'b0;
			if (roll >= 30 && roll < 82) begin
				if ($urandom_range(9) < 8 || edge_limit == DPES_MAX_EDGES) begin
					if (pick_slot(i) && pick_slot(j)) begin
						queue_request(MODE_SWAP, i, j, $urandom_range(255),
							$urandom_range(255), $urandom_range(1));
						ok = 1'b1;
					end
				end else begin
					// at least one slot outside the edges in use
					i = $urandom_range(DPES_MAX_EDGES - 1, edge_limit);
					j = $urandom_range(DPES_MAX_EDGES - 1);
					if ($urandom_range(1))
						queue_request(MODE_SWAP, i, j, $urandom_range(255),
							$urandom_range(255), $urandom_range(1));
					else
						queue_request(MODE_SWAP, j, i, $urandom_range(255),
							$urandom_range(255), $urandom_range(1));
					ok = 1'b1;
				end
			end else if (roll >= 82 && roll < 97 && filled_slots.size() != 0) begin
				slot = filled_slots[$urandom_range(filled_slots.size() - 1)];
				queue_request(MODE_READ, slot, $urandom_range(4095), $urandom_range(255),
					$urandom_range(255), $urandom_range(1));
				ok = 1'b1;
			end else if (roll >= 97) begin
				queue_request(MODE_SPARE, $urandom_range(4095), $urandom_range(4095),
					$urandom_range(255), $urandom_range(255), $urandom_range(1));
				ok = 1'b1;
			end
			if (!ok) begin
				if ($urandom_range(4) != 0 && edge_limit != 0)
					slot = $urandom_range(edge_limit - 1);
				else
					slot = $urandom_range(DPES_MAX_EDGES - 1);
				queue_request(MODE_LOAD, slot, $urandom_range(4095),
					$urandom_range(node_span - 1), $urandom_range(node_span - 1),
					$urandom_range(1));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// no edges in use: every swap is out of range
		begin_phase(0, 0, 0);
		queue_request(MODE_LOAD, 0, 4095, 0, 255, 1'b1);
		queue_request(MODE_LOAD, 4095, 0, 255, 0, 1'b0);
		queue_request(MODE_READ, 4095, 0, 0, 0, 1'b0);
		queue_request(MODE_READ, 0, 0, 0, 0, 1'b0);
		queue_request(MODE_SWAP, 0, 0, 0, 0, 1'b1);
		queue_request(MODE_SWAP, 4095, 4095, 255, 255, 1'b0);
		queue_request(MODE_SPARE, 5, 5, 5, 5, 1'b1);

		begin_phase(8, 0, 0);
		queue_request(MODE_LOAD, 0, 0, 10, 11, 1'b0);  // reload, old bits stay set
		queue_request(MODE_LOAD, 1, 0, 12, 13, 1'b0);
		queue_request(MODE_LOAD, 2, 0, 10, 14, 1'b0);
		queue_request(MODE_LOAD, 3, 0, 20, 20, 1'b0);  // self loop
		queue_request(MODE_LOAD, 4, 0, 21, 22, 1'b0);
		queue_request(MODE_LOAD, 5, 0, 10, 12, 1'b0);
		queue_request(MODE_LOAD, 6, 0, 30, 31, 1'b0);
		queue_request(MODE_LOAD, 6, 0, 32, 33, 1'b0);
		queue_request(MODE_SWAP, 0, 0, 0, 0, 1'b1);    // same slot twice
		queue_request(MODE_SWAP, 0, 2, 0, 0, 1'b0);    // shared node
		queue_request(MODE_SWAP, 0, 1, 0, 0, 1'b1);    // target edge exists
		queue_request(MODE_SWAP, 0, 1, 0, 0, 1'b0);
		queue_request(MODE_READ, 1, 0, 0, 0, 1'b0);
		queue_request(MODE_SWAP, 3, 4, 0, 0, 1'b1);
		queue_request(MODE_SWAP, 8, 0, 0, 0, 1'b1);
		queue_request(MODE_SWAP, 0, 8, 0, 0, 1'b0);
		queue_request(MODE_SWAP, 6, 4, 0, 0, 1'b0);
		queue_request(MODE_READ, 4, 0, 0, 0, 1'b0);

		begin_phase(4096, 0, 0);
		add_random_items(300, 256);
		begin_phase(64, 67, 0);
		add_random_items(300, 16);
		begin_phase(2, 0, 67);
		add_random_items(150, 8);
		begin_phase(1000, 11, 11);
		add_random_items(175, 64);
		wait_drained();
		add_random_items(175, 64);
		begin_phase(1, 67, 67);
		add_random_items(100, 8);
		begin_phase(300, 0, 67);
		add_random_items(400, 32);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule
